[rtl/core/sfd_pkg.sv]
// Shared types and constants for the sensor frame deframer.
package sfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned PART_W   = 24;
    localparam int unsigned COORD_W  = 16;
    localparam int unsigned DIST_W   = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h23;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h66;
    localparam logic [BYTE_W-1:0] TAIL_BYTE_RST     = 8'h11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE     = 2'd2;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_HDR0   = 4'd0;
    localparam logic [POS_W-1:0] POS_HDR1   = 4'd1;
    localparam logic [POS_W-1:0] POS_X_LO   = 4'd2;
    localparam logic [POS_W-1:0] POS_X_HI   = 4'd3;
    localparam logic [POS_W-1:0] POS_Y_LO   = 4'd4;
    localparam logic [POS_W-1:0] POS_Y_HI   = 4'd5;
    localparam logic [POS_W-1:0] POS_D0     = 4'd6;
    localparam logic [POS_W-1:0] POS_D1     = 4'd7;
    localparam logic [POS_W-1:0] POS_D2     = 4'd8;
    localparam logic [POS_W-1:0] POS_D3     = 4'd9;
    localparam logic [POS_W-1:0] POS_TAIL   = 4'd10;
    localparam logic [POS_W-1:0] POS_IGNORE = 4'd11;

    typedef enum logic [2:0] {
        EV_X_UPDATED    = 3'd0,
        EV_Y_UPDATED    = 3'd1,
        EV_DIST_UPDATED = 3'd2,
        EV_TAIL_OK      = 3'd3,
        EV_TAIL_BAD     = 3'd4
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] tail_byte;
    } cfg_t;

    typedef struct packed {
        event_t             evt;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [DIST_W-1:0]  distance;
    } result_t;

endpackage

[rtl/core/sfd_cfg_regs.sv]
// Configuration registers: expected header and tail bytes.
module sfd_cfg_regs
    import sfd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_first  <= HEADER_FIRST_RST;
            cfg_reg.header_second <= HEADER_SECOND_RST;
            cfg_reg.tail_byte     <= TAIL_BYTE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data;
                CFG_HEADER_SECOND: cfg_reg.header_second <= cfg_data;
                CFG_TAIL_BYTE:     cfg_reg.tail_byte     <= cfg_data;
                default:           ; // index beyond the register list is dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/sfd_parser.sv]
// Frame position tracking and field assembly, one byte per cycle while accept is high.
module sfd_parser
    import sfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              accept,
    input  logic [BYTE_W-1:0] rx_byte,
    output logic              res_load,
    output result_t           res
);

    logic [POS_W-1:0]   pos_reg,  pos_next;
    logic [PART_W-1:0]  part_reg, part_next;
    logic [COORD_W-1:0] x_reg,    x_next;
    logic [COORD_W-1:0] y_reg,    y_next;
    logic [DIST_W-1:0]  dist_reg, dist_next;
    logic               emit;
    event_t             evt;

    always_comb
    begin
        pos_next  = pos_reg;
        part_next = part_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        dist_next = dist_reg;
        emit      = 1'b0;
        evt       = EV_X_UPDATED;
        unique case (pos_reg)
            POS_HDR0:
                pos_next = (rx_byte == cfg.header_first) ? POS_HDR1 : POS_HDR0;
            POS_HDR1:
                pos_next = (rx_byte == cfg.header_second) ? POS_X_LO : POS_HDR0;
            POS_X_LO, POS_Y_LO, POS_D0:
            begin
                part_next = {16'd0, rx_byte};
                pos_next  = pos_reg + 4'd1;
            end
            POS_X_HI:
            begin
                x_next   = {rx_byte, part_reg[7:0]};
                pos_next = POS_Y_LO;
                emit     = 1'b1;
                evt      = EV_X_UPDATED;
            end
            POS_Y_HI:
            begin
                y_next   = {rx_byte, part_reg[7:0]};
                pos_next = POS_D0;
                emit     = 1'b1;
                evt      = EV_Y_UPDATED;
            end
            POS_D1:
            begin
                part_next = {8'd0, rx_byte, part_reg[7:0]};
                pos_next  = POS_D2;
            end
            POS_D2:
            begin
                part_next = {rx_byte, part_reg[15:0]};
                pos_next  = POS_D3;
            end
            POS_D3:
            begin
                dist_next = {rx_byte, part_reg[23:0]};
                pos_next  = POS_TAIL;
                emit      = 1'b1;
                evt       = EV_DIST_UPDATED;
            end
            POS_TAIL:
            begin
                emit = 1'b1;
                if (rx_byte == cfg.tail_byte)
                begin
                    pos_next = POS_IGNORE;
                    evt      = EV_TAIL_OK;
                end
                else
                begin
                    pos_next = POS_HDR0;
                    evt      = EV_TAIL_BAD;
                end
            end
            default:
                pos_next = POS_HDR0; // trailing byte, or an unreachable position
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= POS_HDR0;
            part_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            dist_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg  <= pos_next;
            part_reg <= part_next;
            x_reg    <= x_next;
            y_reg    <= y_next;
            dist_reg <= dist_next;
        end
    end

    // result carries the values as they stand after this byte
    assign res_load     = accept & emit;
    assign res.evt      = evt;
    assign res.x        = x_next;
    assign res.y        = y_next;
    assign res.distance = dist_next;

endmodule

[rtl/core/sfd_out_stage.sv]
// Output register holding one result item until the receiver takes it.
module sfd_out_stage
    import sfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_load,
    input  result_t res,
    input  logic    out_stall,
    output logic    out_valid,
    output logic    busy,
    output result_t out_res
);

    logic    valid_reg;
    result_t data_reg;

    // a held item blocks new input; otherwise the register refills each cycle
    assign busy = valid_reg & out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!busy)
        begin
            valid_reg <= res_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!busy && res_load)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

[rtl/core/sensor_frame_deframer_unit.sv]
// Top level of the sensor frame deframer.
//
// Input channel: one received byte per item on rx_byte, handshaked by
// in_valid / in_stall. Output channel: one result item per commit of X, Y
// or distance and per tail check, on event_res, x_pos, y_pos and
// distance_bits, handshaked by out_valid / out_stall. Header bytes and the
// trailing byte of a frame produce no item.
// A result is registered and appears on the outputs in the cycle after its
// byte is accepted. Throughput: one byte per cycle while in_stall is low, set
// by the single position counter and the one-entry output register.
// When the receiver stalls with a result held, in_stall rises and input is
// held off until that item is taken; a byte that gives no result is still
// only taken once the output register is free.
// Configuration: cfg_we writes register cfg_index (0 first header byte,
// 1 second header byte, 2 tail byte); other indexes are ignored.
// Reset: asynchronous, active low; the block hunts for a header, committed
// values are cleared to zero and the expected bytes return to 0x23, 0x66 and 0x11.
module sensor_frame_deframer_unit
    import sfd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [BYTE_W-1:0]         cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [BYTE_W-1:0]         rx_byte,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                event_res,
    output logic signed [COORD_W-1:0] x_pos,
    output logic signed [COORD_W-1:0] y_pos,
    output logic [DIST_W-1:0]         distance_bits
);

    cfg_t    cfg;
    logic    accept;
    logic    res_load;
    logic    busy;
    result_t res;
    result_t out_res;

    sfd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_stall = busy;
    assign accept   = in_valid & ~busy;

    sfd_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .accept   (accept),
        .rx_byte  (rx_byte),
        .res_load (res_load),
        .res      (res)
    );

    sfd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_load  (res_load),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .busy      (busy),
        .out_res   (out_res)
    );

    assign event_res     = out_res.evt;
    assign x_pos         = out_res.x;
    assign y_pos         = out_res.y;
    assign distance_bits = out_res.distance;

endmodule
